/* design/a4icd_pkg.sv */
// ----------------------------------------------------------------------------
// ARMv4T instruction class decoder package
// Shared class codes and the decoded-result structure.
// ----------------------------------------------------------------------------
`default_nettype none

package a4icd_pkg;

  typedef logic [4:0] class_t;

  // Thumb formats 1 through 19, then Thumb undefined.
  localparam class_t T_MOVE_SHIFTED = 5'd0;
  localparam class_t T_ADD_SUB      = 5'd1;
  localparam class_t T_IMM_OP       = 5'd2;
  localparam class_t T_ALU_OP       = 5'd3;
  localparam class_t T_HI_REG       = 5'd4;
  localparam class_t T_PC_LOAD      = 5'd5;
  localparam class_t T_LS_REG       = 5'd6;
  localparam class_t T_LS_SIGN      = 5'd7;
  localparam class_t T_LS_IMM       = 5'd8;
  localparam class_t T_LS_HALF      = 5'd9;
  localparam class_t T_SP_LS        = 5'd10;
  localparam class_t T_LOAD_ADDR    = 5'd11;
  localparam class_t T_ADD_SP       = 5'd12;
  localparam class_t T_PUSH_POP     = 5'd13;
  localparam class_t T_MULTI_LS     = 5'd14;
  localparam class_t T_COND_BR      = 5'd15;
  localparam class_t T_SWI          = 5'd16;
  localparam class_t T_BRANCH       = 5'd17;
  localparam class_t T_LONG_BL      = 5'd18;
  localparam class_t T_UNDEF        = 5'd19;

  // ARM classes.
  localparam class_t A_DATA_PROC    = 5'd20;
  localparam class_t A_PSR          = 5'd21;
  localparam class_t A_BX           = 5'd22;
  localparam class_t A_MUL          = 5'd23;
  localparam class_t A_MUL_LONG     = 5'd24;
  localparam class_t A_SWAP         = 5'd25;
  localparam class_t A_HALF_XFER    = 5'd26;
  localparam class_t A_SINGLE_XFER  = 5'd27;
  localparam class_t A_BLOCK_XFER   = 5'd28;
  localparam class_t A_BRANCH       = 5'd29;
  localparam class_t A_SWI          = 5'd30;
  localparam class_t A_UNDEF        = 5'd31;

  typedef struct packed {
    class_t     insn_class;
    logic [3:0] op_code;
    logic [2:0] reg_select;
    logic [4:0] small_imm;
    logic       imm_flag;
    logic       s_flag;
    logic       pre_index;
    logic       add_offset;
    logic       write_back;
    logic       load_flag;
    logic       flag_a;
    logic       flag_b;
  } dec_t;

endpackage

`default_nettype wire

/* design/armv4t_instruction_class_decoder.sv */
// A request accepted into the input register is decoded there and moves on into
// the result register whenever that is free; the two do not advance in lockstep.
// Throughput: one request per cycle, sustained, while the result side takes them.
// The rate is set by the single decode stage between the input register and the
// result register; both registers together form one two-entry pipeline.
// Reset (rst_n low, synchronous) empties both stages; payload registers keep data.
// ----------------------------------------------------------------------------
// ARMv4T instruction class decoder
// Two-register decode pipeline that classifies an ARM or Thumb instruction
// and extracts the operation, register, offset and flag fields of its class.
// ----------------------------------------------------------------------------
`default_nettype none

module armv4t_instruction_class_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_instr_word,
  input  wire logic        in_thumb_mode,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [4:0]       out_insn_class,
  output logic [3:0]       out_op_code,
  output logic [2:0]       out_reg_select,
  output logic [4:0]       out_small_imm,
  output logic             out_imm_flag,
  output logic             out_s_flag,
  output logic             out_pre_index,
  output logic             out_add_offset,
  output logic             out_write_back,
  output logic             out_load_flag,
  output logic             out_flag_a,
  output logic             out_flag_b
);

  // Input stage: the request waits here while its decode is computed.
  logic        s1_v_r;
  logic        s1_v_nxt;
  logic [31:0] s1_word_r;
  logic        s1_thumb_r;

  // Result stage: the decoded fields wait here until the consumer takes them.
  logic            out_v_r;
  logic            out_v_nxt;
  a4icd_pkg::dec_t out_res_r;

  a4icd_pkg::dec_t thumb_res;
  a4icd_pkg::dec_t arm_res;
  a4icd_pkg::dec_t dec_res;

  logic in_take;
  logic out_take;
  logic s1_move;

  // The result register is free when empty or when its request leaves this
  // cycle. The input stage moves forward whenever it holds a request and the
  // result register is free; it accepts a new request whenever it is empty or
  // moving, so a stalled result does not block the input until both fill up.
  assign out_take = out_v_r && !out_stall;
  assign s1_move  = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall = s1_v_r && !s1_move;
  assign in_take  = in_valid && !in_stall;

  assign s1_v_nxt  = in_take || (s1_v_r && !s1_move);
  assign out_v_nxt = s1_move || (out_v_r && !out_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_word_r  <= in_instr_word;
      s1_thumb_r <= in_thumb_mode;
    end
  end

  // Both decoders look at the held word; the mode bit picks the answer.
  a4icd_thumb_dec u_thumb_dec (
    .half (s1_word_r[15:0]),
    .res  (thumb_res)
  );

  a4icd_arm_dec u_arm_dec (
    .word (s1_word_r),
    .res  (arm_res)
  );

  assign dec_res = s1_thumb_r ? thumb_res : arm_res;

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_res_r <= dec_res;
    end
  end

  assign out_valid      = out_v_r;
  assign out_insn_class = out_res_r.insn_class;
  assign out_op_code    = out_res_r.op_code;
  assign out_reg_select = out_res_r.reg_select;
  assign out_small_imm  = out_res_r.small_imm;
  assign out_imm_flag   = out_res_r.imm_flag;
  assign out_s_flag     = out_res_r.s_flag;
  assign out_pre_index  = out_res_r.pre_index;
  assign out_add_offset = out_res_r.add_offset;
  assign out_write_back = out_res_r.write_back;
  assign out_load_flag  = out_res_r.load_flag;
  assign out_flag_a     = out_res_r.flag_a;
  assign out_flag_b     = out_res_r.flag_b;

  // An accepted request always lands in the input stage.
  a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> s1_v_r)
    else $error("accepted request did not reach the input stage");

  // A blocked input stage keeps its request unchanged.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_move) |=> (s1_v_r && $stable(s1_word_r) && $stable(s1_thumb_r)))
    else $error("blocked input stage lost or changed its request");

  // A request moving out of the input stage shows up as a result.
  a_move_fills: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> out_v_r)
    else $error("decoded request did not reach the result register");

  // Thumb words decode only to Thumb classes.
  a_thumb_range: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_thumb_r) |-> (dec_res.insn_class <= a4icd_pkg::T_UNDEF))
    else $error("Thumb word decoded to an ARM class");

  // ARM words decode only to ARM classes.
  a_arm_range: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_thumb_r) |-> (dec_res.insn_class >= a4icd_pkg::A_DATA_PROC))
    else $error("ARM word decoded to a Thumb class");

endmodule

`default_nettype wire

/* design/a4icd_thumb_dec.sv */
// ----------------------------------------------------------------------------
// Thumb format decoder
// Ordered first-match decode of one 16-bit Thumb instruction.
// ----------------------------------------------------------------------------
`default_nettype none

module a4icd_thumb_dec (
  input  wire logic [15:0]     half,
  output a4icd_pkg::dec_t      res
);

  always_comb begin
    res = '0;
    if (half[15:11] < 5'd3) begin
      res.insn_class = a4icd_pkg::T_MOVE_SHIFTED;
      res.op_code    = {2'b00, half[12:11]};
      res.small_imm  = half[10:6];
    end else if (half[15:11] == 5'b00011) begin
      res.insn_class = a4icd_pkg::T_ADD_SUB;
      res.imm_flag   = half[10];
      res.flag_a     = half[9];
      res.small_imm  = {2'b00, half[8:6]};
    end else if (half[15:13] == 3'b001) begin
      res.insn_class = a4icd_pkg::T_IMM_OP;
      res.op_code    = {2'b00, half[12:11]};
      res.reg_select = half[10:8];
    end else if (half[15:10] == 6'b010000) begin
      res.insn_class = a4icd_pkg::T_ALU_OP;
      res.op_code    = half[9:6];
    end else if (half[15:10] == 6'b010001) begin
      res.insn_class = a4icd_pkg::T_HI_REG;
      res.op_code    = {2'b00, half[9:8]};
      res.flag_a     = half[7];
      res.flag_b     = half[6];
    end else if (half[15:11] == 5'b01001) begin
      res.insn_class = a4icd_pkg::T_PC_LOAD;
      res.reg_select = half[10:8];
    end else if (half[15:12] == 4'b0101) begin
      // Bit 9 splits register-offset from sign-extended transfers.
      res.insn_class = half[9] ? a4icd_pkg::T_LS_SIGN : a4icd_pkg::T_LS_REG;
      res.op_code    = {2'b00, half[11:10]};
      res.reg_select = half[8:6];
    end else if (half[15:13] == 3'b011) begin
      res.insn_class = a4icd_pkg::T_LS_IMM;
      res.op_code    = {2'b00, half[12:11]};
      res.small_imm  = half[10:6];
    end else if (half[15:12] == 4'b1000) begin
      res.insn_class = a4icd_pkg::T_LS_HALF;
      res.load_flag  = half[11];
      res.small_imm  = half[10:6];
    end else if (half[15:12] == 4'b1001) begin
      res.insn_class = a4icd_pkg::T_SP_LS;
      res.load_flag  = half[11];
      res.reg_select = half[10:8];
    end else if (half[15:12] == 4'b1010) begin
      res.insn_class = a4icd_pkg::T_LOAD_ADDR;
      res.op_code    = {3'b000, half[11]};
      res.reg_select = half[10:8];
    end else if (half[15:8] == 8'hB0) begin
      res.insn_class = a4icd_pkg::T_ADD_SP;
      res.flag_a     = half[7];
    end else if (half[15:12] == 4'b1011 && half[10:9] == 2'b10) begin
      res.insn_class = a4icd_pkg::T_PUSH_POP;
      res.load_flag  = half[11];
      res.flag_a     = half[8];
    end else if (half[15:12] == 4'b1100) begin
      res.insn_class = a4icd_pkg::T_MULTI_LS;
      res.load_flag  = half[11];
      res.reg_select = half[10:8];
    end else if (half[15:8] < 8'hDF) begin
      // Also catches the unassigned B-space codes.
      res.insn_class = a4icd_pkg::T_COND_BR;
      res.op_code    = half[11:8];
    end else if (half[15:8] == 8'hDF) begin
      res.insn_class = a4icd_pkg::T_SWI;
    end else if (half[15:11] == 5'b11100) begin
      res.insn_class = a4icd_pkg::T_BRANCH;
    end else if (half[15:12] == 4'b1111) begin
      res.insn_class = a4icd_pkg::T_LONG_BL;
      res.op_code    = {3'b000, half[11]};
    end else begin
      res.insn_class = a4icd_pkg::T_UNDEF;
    end
  end

endmodule

`default_nettype wire

/* design/a4icd_arm_dec.sv */
// ----------------------------------------------------------------------------
// ARM class decoder
// Sorts a 32-bit ARM word by bits 27-20 and 7-4 and extracts its fields.
// ----------------------------------------------------------------------------
`default_nettype none

module a4icd_arm_dec (
  input  wire logic [31:0]     word,
  output a4icd_pkg::dec_t      res
);

  logic [3:0] lo_nib;
  logic [3:0] alu_op;
  logic       is_psr;

  assign lo_nib = word[7:4];
  assign alu_op = word[24:21];
  // TST/TEQ/CMP/CMN without the S bit are PSR transfers.
  assign is_psr = !word[20] && (alu_op[3:2] == 2'b10);

  always_comb begin
    res = '0;
    case (word[27:26])
      2'b00: begin
        if (!word[25] && word[27:20] == 8'h12 && lo_nib == 4'h1) begin
          res.insn_class = a4icd_pkg::A_BX;
        end else if (!word[25] && !word[24] && lo_nib == 4'h9) begin
          res.flag_a = word[21];
          res.s_flag = word[20];
          if (word[23]) begin
            res.insn_class = a4icd_pkg::A_MUL_LONG;
            res.flag_b     = word[22];
          end else begin
            res.insn_class = a4icd_pkg::A_MUL;
          end
        end else if (!word[25] && word[24] && lo_nib == 4'h9) begin
          res.insn_class = a4icd_pkg::A_SWAP;
          res.flag_a     = word[22];
        end else if (!word[25] && (lo_nib == 4'hB || (lo_nib[3] && lo_nib[2] && lo_nib[0]))) begin
          res.insn_class = a4icd_pkg::A_HALF_XFER;
          res.pre_index  = word[24];
          res.add_offset = word[23];
          res.write_back = word[21];
          res.load_flag  = word[20];
          res.imm_flag   = word[22];
          res.op_code    = {2'b00, word[6:5]};
        end else begin
          res.imm_flag = word[25];
          if (is_psr) begin
            res.insn_class = a4icd_pkg::A_PSR;
            res.flag_a     = word[22];
            res.flag_b     = word[21];
          end else begin
            res.insn_class = a4icd_pkg::A_DATA_PROC;
            res.op_code    = alu_op;
            res.s_flag     = word[20];
            res.small_imm  = {1'b0, lo_nib};
          end
        end
      end
      2'b01: begin
        if (word[25] && word[4]) begin
          res.insn_class = a4icd_pkg::A_UNDEF;
        end else begin
          res.insn_class = a4icd_pkg::A_SINGLE_XFER;
          res.pre_index  = word[24];
          res.add_offset = word[23];
          res.write_back = word[21];
          res.load_flag  = word[20];
          res.imm_flag   = ~word[25];
          res.flag_a     = word[22];
        end
      end
      2'b10: begin
        if (word[25]) begin
          res.insn_class = a4icd_pkg::A_BRANCH;
          res.flag_a     = word[24];
        end else begin
          res.insn_class = a4icd_pkg::A_BLOCK_XFER;
          res.pre_index  = word[24];
          res.add_offset = word[23];
          res.write_back = word[21];
          res.load_flag  = word[20];
          res.flag_a     = word[22];
        end
      end
      default: begin
        // Coprocessor space is undefined; only bits 25-24 set mean SWI.
        res.insn_class = (word[25:24] == 2'b11) ? a4icd_pkg::A_SWI : a4icd_pkg::A_UNDEF;
      end
    endcase
  end

endmodule

`default_nettype wire
